/* design/bsc_pkg.sv */
// bsc_pkg: shared constants, register map and result descriptor for the
// bmp stream crop block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

  // largest supported source dimension in pixels or rows
  localparam int unsigned MAX_DIM = 4096;

  localparam int DIM_W  = 13;   // width, height and crop size registers
  localparam int POS_W  = 12;   // crop corner registers
  localparam int BPP_W  = 2;
  localparam int COL_W  = 14;   // byte column within the padded source stride
  localparam int ROW_W  = 12;   // file row counter
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BPP        = 3'd2;
  localparam logic [2:0] REG_CROP_X     = 3'd3;
  localparam logic [2:0] REG_CROP_Y     = 3'd4;
  localparam logic [2:0] REG_CROP_W     = 3'd5;
  localparam logic [2:0] REG_CROP_H     = 3'd6;

  // one source byte worth of results, replayed word by word on the output
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              err;      // bad configuration, single error word
    logic              last;     // last window byte of its row
    logic              img_end;  // that row is the top row of the window
    logic [1:0]        pads;     // padding words after the last byte
  } desc_t;

endpackage

`default_nettype wire

/* design/bmp_stream_crop.sv */
// bmp_stream_crop: top level of the streaming bmp crop, with its apb
// register bank. Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   s_* : source pixel-data words of a bottom-up bmp in file order, row
//         padding included. s_tuser marks the first word of an image and
//         restarts the column and row counters.
//   m_* : cropped words; inserted zero padding brings every output row to a
//         multiple of four bytes. m_tlast ends an output row.
//   apb : seven registers at byte addresses 0 to 24, written while idle.
// Timing
//   a word accepted is held in the input register, decoded there and its first
//   result registered onto m_tvalid. One source word per cycle is taken while
//   the result register is free or the word has no result; the last window word
//   of a row carries up to three padding words, and the input register holds the
//   next word while the result register replays them, one per cycle with m_tready.
// Reset clears the pipeline and counters and loads the register defaults.
// When the receiver stalls the result register holds its word and the input
// register still takes source words until it holds one with a result.
// A bad setting (bytes per pixel not 2 or 3, a zero or oversize source, or a
// window that does not fit it) gives one size_error word per source word.
module bmp_stream_crop
  import bsc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // source stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] pixel_byte
  input  wire logic [0:0]        s_tuser,   // [0] first_of_image
  // cropped stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
  output logic                   m_tlast,   // row_end
  output logic [2:0]             m_tuser,   // [0] is_padding [1] image_end [2] size_error
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  // registers
  logic [DIM_W-1:0] src_width, src_height, crop_w, crop_h;
  logic [POS_W-1:0] crop_x, crop_y;
  logic [BPP_W-1:0] bytes_per_pixel;

  logic             apb_wr;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign apb_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width       <= DIM_W'(1);
      src_height      <= DIM_W'(1);
      bytes_per_pixel <= BPP_W'(3);
      crop_x          <= '0;
      crop_y          <= '0;
      crop_w          <= DIM_W'(1);
      crop_h          <= DIM_W'(1);
    end else if (apb_wr) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:  src_width       <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height      <= pwdata[DIM_W-1:0];
        REG_BPP:        bytes_per_pixel <= pwdata[BPP_W-1:0];
        REG_CROP_X:     crop_x          <= pwdata[POS_W-1:0];
        REG_CROP_Y:     crop_y          <= pwdata[POS_W-1:0];
        REG_CROP_W:     crop_w          <= pwdata[DIM_W-1:0];
        REG_CROP_H:     crop_h          <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:  prdata = DATA_W'(src_width);
      REG_SRC_HEIGHT: prdata = DATA_W'(src_height);
      REG_BPP:        prdata = DATA_W'(bytes_per_pixel);
      REG_CROP_X:     prdata = DATA_W'(crop_x);
      REG_CROP_Y:     prdata = DATA_W'(crop_y);
      REG_CROP_W:     prdata = DATA_W'(crop_w);
      REG_CROP_H:     prdata = DATA_W'(crop_h);
      default:        prdata = '0;
    endcase
  end

  // window geometry, registered once per cycle from the registers
  logic [14:0] src_bytes, row_bytes, x0_next, stride_next, x_end_next;
  logic [13:0] lo_next, hi_next;
  logic [1:0]  pads_next;
  logic        cfg_ok_next, win_next;

  logic [14:0] stride, x0, x_end, last_col;
  logic [13:0] lo, hi;
  logic [1:0]  pads;
  logic        cfg_ok, win;

  always_comb begin
    src_bytes   = 15'(src_width) * 15'(bytes_per_pixel);
    row_bytes   = 15'(crop_w) * 15'(bytes_per_pixel);
    x0_next     = 15'(crop_x) * 15'(bytes_per_pixel);
    stride_next = (src_bytes + 15'd3) & ~15'd3;
    x_end_next  = x0_next + row_bytes;
    pads_next   = 2'(2'd0 - row_bytes[1:0]);
    lo_next     = 14'(src_height) - 14'(crop_y) - 14'(crop_h);
    hi_next     = 14'(src_height) - 14'(crop_y) - 14'd1;
    win_next    = (crop_w != '0) && (crop_h != '0);
    cfg_ok_next = (bytes_per_pixel == BPP_W'(2) || bytes_per_pixel == BPP_W'(3)) &&
                  src_width  != '0 && src_width  <= DIM_W'(MAX_DIM) &&
                  src_height != '0 && src_height <= DIM_W'(MAX_DIM) &&
                  (14'(crop_x) + 14'(crop_w)) <= 14'(src_width) &&
                  (14'(crop_y) + 14'(crop_h)) <= 14'(src_height);
  end

  always_ff @(posedge clk) begin
    stride   <= stride_next;
    x0       <= x0_next;
    x_end    <= x_end_next;
    last_col <= x_end_next - 15'd1;
    lo       <= lo_next;
    hi       <= hi_next;
    pads     <= pads_next;
    win      <= win_next;
    cfg_ok   <= cfg_ok_next;
  end

  // input register
  logic              in_valid, in_first, in_take;
  logic [BYTE_W-1:0] in_byte;

  assign s_tready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (in_take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser[0];
    end
  end

  // locate the held word and work out its results
  logic [COL_W-1:0] byte_column, col, col_next;
  logic [ROW_W-1:0] source_row, row, row_next;
  logic [14:0]      col_inc;
  logic [12:0]      row_inc;
  logic             in_win, has_res;
  desc_t            desc_next;

  always_comb begin
    col      = in_first ? '0 : byte_column;
    row      = in_first ? '0 : source_row;
    col_inc  = 15'(col) + 15'd1;
    row_inc  = 13'(row) + 13'd1;
    in_win   = win &&
               14'(row) >= lo && 14'(row) <= hi &&
               15'(col) >= x0 && 15'(col) < x_end;

    desc_next.data    = in_byte;
    desc_next.err     = 1'b0;
    desc_next.last    = 15'(col) == last_col;
    desc_next.img_end = 14'(row) == hi;
    desc_next.pads    = pads;

    if (!cfg_ok) begin
      // counters hold, first word still clears them
      col_next       = col;
      row_next       = row;
      has_res        = 1'b1;
      desc_next      = '0;
      desc_next.err  = 1'b1;
    end else begin
      has_res = in_win;
      if (col_inc >= stride) begin
        col_next = '0;
        row_next = (row_inc >= src_height) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_next = col_inc[COL_W-1:0];
        row_next = row;
      end
    end
  end

  // result register, replays one descriptor as one to four words
  desc_t      res;
  logic       res_valid, res_free, last_word;
  logic [1:0] res_idx, res_last_idx;

  assign res_last_idx = res.last ? res.pads : 2'd0;
  assign last_word    = res_idx == res_last_idx;
  assign res_free     = !res_valid || (m_tready && last_word);
  assign in_take      = in_valid && (!has_res || res_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      source_row  <= '0;
    end else if (in_take) begin
      byte_column <= col_next;
      source_row  <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_idx   <= '0;
    end else if (in_take && has_res) begin
      res_valid <= 1'b1;
      res_idx   <= '0;
    end else if (res_valid && m_tready) begin
      if (last_word) begin
        res_valid <= 1'b0;
      end else begin
        res_idx <= res_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && has_res) begin
      res <= desc_next;
    end
  end

  // word zero is the source byte, later words are zero padding
  logic res_final;

  assign res_final  = !res.err && res.last && last_word;
  assign m_tvalid   = res_valid;
  assign m_tdata    = (res.err || res_idx != 2'd0) ? '0 : res.data;
  assign m_tlast    = res_final;
  assign m_tuser[0] = !res.err && res_idx != 2'd0;
  assign m_tuser[1] = res_final && res.img_end;
  assign m_tuser[2] = res.err;

  // checks
  a_img_end_ends_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("image end without row end");

  a_err_word_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tdata == '0 && !m_tlast && !m_tuser[0])
    else $error("size error word carries data");

  a_pad_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("padding word not zero");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_idx <= res_last_idx)
    else $error("replay index past last word");

endmodule

`default_nettype wire

/* test/bmp_stream_crop_tb.sv */
// bmp_stream_crop_tb: self-checking bench for the streaming bmp crop, with
// directed, random and back-pressure stimulus and a built-in crop predictor.
// Depends on bsc_pkg and the bmp_stream_crop rtl.
`timescale 1ns / 1ps

module bmp_stream_crop_tb;
  import bsc_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic              first;
  } src_byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_padding;
    logic              row_end;
    logic              image_end;
    logic              size_error;
  } crop_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [BYTE_W-1:0] s_tdata = '0;
  logic [0:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [BYTE_W-1:0] m_tdata;
  logic              m_tlast;
  logic [2:0]        m_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bmp_stream_crop u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // predictor copy of the register bank and counters
  logic [DIM_W-1:0] cfg_src_w  = 13'd1;
  logic [DIM_W-1:0] cfg_src_h  = 13'd1;
  logic [BPP_W-1:0] cfg_bpp    = 2'd3;
  logic [POS_W-1:0] cfg_crop_x = '0;
  logic [POS_W-1:0] cfg_crop_y = '0;
  logic [DIM_W-1:0] cfg_crop_w = 13'd1;
  logic [DIM_W-1:0] cfg_crop_h = 13'd1;
  logic [COL_W-1:0] col_q = '0;
  logic [ROW_W-1:0] row_q = '0;

  src_byte_t  src_bytes_q[$];
  crop_word_t crop_words_q[$];
  src_byte_t  nxt_byte;
  crop_word_t want;

  int errors = 0;
  int src_words = 0;
  int out_words = 0;
  int predicted_words = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int idle_src[4]  = '{0, 50, 0, 7};
  int idle_sink[4] = '{0, 0, 50, 7};
  bit src_taken = 1'b0;
  bit hold_go = 1'b0;
  bit sink_hold = 1'b0;

  function automatic int unsigned round4(int unsigned v);
    return (v + 3) & ~32'd3;
  endfunction

  function automatic void push_word(logic [7:0] b, bit pad, bit re, bit ie, bit err);
    crop_words_q.push_back('{b, pad, re, ie, err});
    predicted_words++;
  endfunction

  function automatic void predict_crop(logic [7:0] pix, logic first);
    int unsigned c, r, sw, sh, bpp, cx, cy, cw, ch;
    int unsigned stride, x0, row_bytes, lo, hi, pads;
    bit ok, last, ie;
    c = first ? 0 : col_q;
    r = first ? 0 : row_q;
    sw = cfg_src_w; sh = cfg_src_h; bpp = cfg_bpp;
    cx = cfg_crop_x; cy = cfg_crop_y; cw = cfg_crop_w; ch = cfg_crop_h;
    ok = (bpp == 2 || bpp == 3) && sw >= 1 && sw <= MAX_DIM && sh >= 1 &&
         sh <= MAX_DIM && cx + cw <= sw && cy + ch <= sh;
    if (!ok) begin
      // counters hold, but a first-of-image word still clears them
      col_q = c;
      row_q = r;
      push_word(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      return;
    end
    stride = round4(sw * bpp);
    x0 = cx * bpp;
    row_bytes = cw * bpp;
    if (cw != 0 && ch != 0) begin
      lo = sh - cy - ch;
      hi = sh - cy - 1;
      if (r >= lo && r <= hi && c >= x0 && c < x0 + row_bytes) begin
        pads = round4(row_bytes) - row_bytes;
        last = (c == x0 + row_bytes - 1);
        ie = last && r == hi;
        push_word(pix, 1'b0, last && pads == 0, last && pads == 0 && ie, 1'b0);
        if (last) begin
          for (int unsigned i = 0; i < pads; i++)
            push_word(8'h00, 1'b1, i + 1 == pads, i + 1 == pads && ie, 1'b0);
        end
      end
    end
    c++;
    if (c >= stride) begin
      c = 0;
      r++;
      if (r >= sh)
        r = 0;
    end
    col_q = c[COL_W-1:0];
    row_q = r[ROW_W-1:0];
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // source driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || src_taken) begin
      if (src_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt_byte = src_bytes_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt_byte.pixel;
        s_tuser  <= nxt_byte.first;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with the long hold-off overriding the random stalls
  always @(negedge clk)
    m_tready <= !rst && !sink_hold && ($urandom_range(99) >= sink_stall_pct);

  initial begin
    wait (hold_go);
    @(negedge clk);
    sink_hold <= 1'b1;
    repeat (300) @(negedge clk);
    sink_hold <= 1'b0;
  end

  // monitor: predict on each source word, check each cropped word
  always @(posedge clk) begin
    src_taken <= !rst && s_tvalid && s_tready;
    if (rst) begin
      col_q = '0;
      row_q = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_crop(s_tdata, s_tuser[0]);
        src_words++;
      end
      if (m_tvalid && m_tready) begin
        out_words++;
        if (crop_words_q.size() == 0) begin
          $error("out_byte: expected no word, got %0h", m_tdata);
          errors++;
        end else begin
          want = crop_words_q.pop_front();
          check_field("out_byte", want.out_byte, m_tdata);
          check_field("is_padding", want.is_padding, m_tuser[0]);
          check_field("row_end", want.row_end, m_tlast);
          check_field("image_end", want.image_end, m_tuser[1]);
          check_field("size_error", want.size_error, m_tuser[2]);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:  cfg_src_w  = val[DIM_W-1:0];
      REG_SRC_HEIGHT: cfg_src_h  = val[DIM_W-1:0];
      REG_BPP:        cfg_bpp    = val[BPP_W-1:0];
      REG_CROP_X:     cfg_crop_x = val[POS_W-1:0];
      REG_CROP_Y:     cfg_crop_y = val[POS_W-1:0];
      REG_CROP_W:     cfg_crop_w = val[DIM_W-1:0];
      REG_CROP_H:     cfg_crop_h = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_window(int unsigned sw, int unsigned sh, int unsigned bpp,
                            int unsigned cx, int unsigned cy, int unsigned cw,
                            int unsigned ch);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_BPP, bpp);
    write_reg(REG_CROP_X, cx);
    write_reg(REG_CROP_Y, cy);
    write_reg(REG_CROP_W, cw);
    write_reg(REG_CROP_H, ch);
  endtask

  task automatic push_byte(logic [7:0] b, logic first);
    src_bytes_q.push_back('{b, first});
  endtask

  // a whole or partial image; noisy images carry stray restarts
  task automatic queue_image(int unsigned n, bit mark_first, bit noisy);
    for (int unsigned i = 0; i < n; i++)
      push_byte(8'($urandom_range(255)),
                (mark_first && i == 0) || (noisy && $urandom_range(15) == 0));
  endtask

  task automatic set_idle(int mode);
    src_idle_pct   = idle_src[mode];
    sink_stall_pct = idle_sink[mode];
  endtask

  // wait out the results, then the words that give none
  task automatic drain();
    while (src_bytes_q.size() != 0 || s_tvalid || crop_words_q.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    int unsigned sw, sh, bpp, cx, cy, cw, ch, stride, n;
    int phase, rand_start, res_start, windows;
    phase = 0;
    windows = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window: 1x1 at 24 bits, three bytes then one padding word
    set_idle(0);
    push_byte(8'h00, 1'b1); push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b0); push_byte(8'h5A, 1'b0);
    // next image follows on the row wrap alone
    push_byte(8'h3C, 1'b0); push_byte(8'hC3, 1'b0);
    push_byte(8'h81, 1'b0); push_byte(8'h7E, 1'b0);
    // restart part way through
    push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b1);
    push_byte(8'h33, 1'b0); push_byte(8'h44, 1'b0); push_byte(8'h55, 1'b0);
    drain();

    // empty windows
    write_reg(REG_CROP_W, 0);
    push_byte(8'h01, 1'b1); push_byte(8'h02, 1'b0);
    drain();
    write_reg(REG_CROP_W, 1);
    write_reg(REG_CROP_H, 0);
    push_byte(8'h03, 1'b0); push_byte(8'h04, 1'b0);
    drain();
    write_reg(REG_CROP_H, 1);

    // bad configurations, one error word per source word
    write_reg(REG_BPP, 1);
    push_byte(8'h80, 1'b1); push_byte(8'h7F, 1'b0);
    drain();
    write_reg(REG_BPP, 0);
    push_byte(8'h01, 1'b0);
    drain();
    write_reg(REG_BPP, 2);
    write_reg(REG_SRC_WIDTH, 0);
    push_byte(8'h02, 1'b0);
    drain();
    write_reg(REG_SRC_WIDTH, 4097);
    push_byte(8'h04, 1'b1);
    drain();
    write_reg(REG_SRC_WIDTH, 8191);
    push_byte(8'h08, 1'b0);
    drain();
    write_reg(REG_SRC_WIDTH, 1);
    write_reg(REG_CROP_X, 1);
    push_byte(8'h10, 1'b0);
    drain();
    write_reg(REG_CROP_X, 0);
    write_reg(REG_CROP_Y, 1);
    push_byte(8'h20, 1'b0);
    drain();
    write_reg(REG_CROP_Y, 0);
    write_reg(REG_SRC_HEIGHT, 0);
    push_byte(8'h40, 1'b0);
    drain();
    windows += 10;

    // widest window over the bottom row of the tallest source, its first bytes
    set_window(4096, 4096, 2, 0, 4095, 4096, 1);
    queue_image(24, 1'b1, 1'b0);
    drain();
    // widest 24-bit source with only its rightmost pixel in the window
    set_idle(3);
    set_window(4096, 1, 3, 4095, 0, 1, 1);
    queue_image(16, 1'b1, 1'b0);
    drain();

    // long receiver hold-off while the source keeps offering
    set_idle(0);
    set_window(8, 4, 3, 1, 0, 7, 4);
    hold_go = 1'b1;
    queue_image(96, 1'b1, 1'b0);
    drain();
    windows += 3;

    rand_start = src_words;
    res_start = predicted_words;
    while (src_words - rand_start < 160 || predicted_words - res_start < 48) begin
      set_idle(phase % 4);
      phase++;
      windows++;
      if ($urandom_range(9) == 0) begin
        // noise: mostly broken settings
        set_window($urandom_range(8), $urandom_range(5), $urandom_range(3),
                   $urandom_range(8), $urandom_range(5), $urandom_range(8),
                   $urandom_range(5));
        queue_image($urandom_range(8, 3), 1'($urandom_range(1)), 1'b1);
      end else begin
        sw  = $urandom_range(6, 1);
        sh  = $urandom_range(4, 1);
        bpp = $urandom_range(3, 2);
        cw  = ($urandom_range(15) == 0) ? 0 : $urandom_range(sw, 1);
        ch  = ($urandom_range(15) == 0) ? 0 : $urandom_range(sh, 1);
        cx  = $urandom_range(sw - cw);
        cy  = $urandom_range(sh - ch);
        set_window(sw, sh, bpp, cx, cy, cw, ch);
        stride = round4(sw * bpp);
        n = stride * sh;
        if ($urandom_range(7) == 0) begin
          queue_image($urandom_range(n, 1), 1'b1, 1'b1);
        end else begin
          queue_image(n, 1'b1, 1'b0);
          if ($urandom_range(1))
            queue_image(n, 1'($urandom_range(1)), 1'b0);
        end
      end
      drain();
    end

    $display("summary: %0d source words and %0d cropped words over %0d window settings,",
             src_words, out_words, windows);
    $display("summary: including bad settings, empty windows, the largest sizes and a long stall");
    if (errors == 0)
      $display("bmp_stream_crop_tb: clean");
    else
      $display("bmp_stream_crop_tb: errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("bmp_stream_crop_tb: errors");
    $finish;
  end

endmodule

/* sim.f */
design/bsc_pkg.sv
design/bmp_stream_crop.sv
test/bmp_stream_crop_tb.sv
